@@ src/pfe_pkg.sv @@
`timescale 1ns / 1ps

package pfe_pkg;

  // Field widths of the item and result transactions
  localparam int DATA_W   = 32;
  localparam int KIND_W   = 2;
  localparam int OP_W     = 3;
  localparam int DEPTH_W  = 6;
  localparam int STATUS_W = 3;

  typedef logic [KIND_W-1:0]   kind_t;
  typedef logic [OP_W-1:0]     op_t;
  typedef logic [STATUS_W-1:0] status_t;

  // Item kinds
  localparam kind_t KIND_PUSH   = 2'd0;
  localparam kind_t KIND_APPLY  = 2'd1;
  localparam kind_t KIND_FINISH = 2'd2;

  // Operator codes; anything above OP_DIV is a no-op
  localparam op_t OP_ADD = 3'd0;
  localparam op_t OP_SUB = 3'd1;
  localparam op_t OP_MUL = 3'd2;
  localparam op_t OP_DIV = 3'd3;

  // Result status codes
  localparam status_t ST_OK    = 3'd0;
  localparam status_t ST_UNDER = 3'd1;
  localparam status_t ST_OVER  = 3'd2;
  localparam status_t ST_DIV0  = 3'd3;
  localparam status_t ST_SAT   = 3'd4;

  localparam logic [DATA_W-1:0] Q_MAX = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0] Q_MIN = 32'h8000_0000;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic latch;     // capture the incoming item
    logic rd_en;     // read the entry below the top
    logic capture;   // take the left operand and prime the divider
    logic mul_en;    // register the product
    logic div_step;  // one quotient bit
    logic commit;    // update the stack and load the result register
  } pfe_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic need_read;
    logic is_mul;
    logic is_div;
    logic div_zero;
    logic div_last;
    logic out_free;
  } pfe_stat_t;

endpackage

@@ src/pfe_ram.sv @@
`timescale 1ns / 1ps

module pfe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Single write port, registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ src/pfe_ctrl.sv @@
`timescale 1ns / 1ps

module pfe_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  pfe_pkg::pfe_stat_t stat,
  output pfe_pkg::pfe_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_OPND,
    S_MUL,
    S_DIV,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        state_nxt = stat.need_read ? S_OPND : S_DONE;
      end
      S_OPND: begin
        if (stat.is_mul) begin
          state_nxt = S_MUL;
        end else if (stat.is_div && !stat.div_zero) begin
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_MUL: begin
        state_nxt = S_DONE;
      end
      S_DIV: begin
        if (stat.div_last) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Decode commands from the current state
  always_comb begin
    cmd          = '0;
    cmd.latch    = (state_r == S_IDLE) && in_valid;
    cmd.rd_en    = (state_r == S_DECODE) && stat.need_read;
    cmd.capture  = (state_r == S_OPND);
    cmd.mul_en   = (state_r == S_MUL);
    cmd.div_step = (state_r == S_DIV);
    cmd.commit   = (state_r == S_DONE) && stat.out_free;
  end

  assign in_stall = (state_r != S_IDLE);

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ src/pfe_datapath.sv @@
`timescale 1ns / 1ps

module pfe_datapath #(
  parameter int STACK_DEPTH   = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  pfe_pkg::pfe_cmd_t                  cmd,
  output pfe_pkg::pfe_stat_t                 stat,
  input  logic [pfe_pkg::KIND_W-1:0]         in_kind,
  input  logic signed [pfe_pkg::DATA_W-1:0]  in_number_value,
  input  logic [pfe_pkg::OP_W-1:0]           in_operator_code,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [pfe_pkg::DATA_W-1:0]  out_top_value,
  output logic [pfe_pkg::DEPTH_W-1:0]        out_stack_depth,
  output logic [pfe_pkg::STATUS_W-1:0]       out_status
);

  localparam int DW  = pfe_pkg::DATA_W;
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int QW  = DW + FRACTION_BITS;   // dividend and quotient width
  localparam int CW  = $clog2(QW + 1);

  // Latched item
  pfe_pkg::kind_t   kind_r;
  logic [DW-1:0]    num_r;
  pfe_pkg::op_t     op_r;

  // Stack: top in a register, the rest in RAM
  logic [SPW-1:0]   sp_r, sp_nxt;
  logic [DW-1:0]    top_r, top_nxt;
  logic [DW-1:0]    x_r;
  logic [DW-1:0]    rd_data;
  logic             wr_en;

  // Multiplier and divider
  logic signed [2*DW-1:0] prod_r;
  logic [QW-1:0]    dvd_r;
  logic [DW-1:0]    rem_r;
  logic [DW-1:0]    ay_r;
  logic             neg_r;
  logic [CW-1:0]    cnt_r;

  // Result register
  logic                      out_valid_r;
  logic [DW-1:0]             out_top_r;
  logic [pfe_pkg::DEPTH_W-1:0] out_depth_r;
  pfe_pkg::status_t          out_status_r;

  // Combinational terms
  logic             has_two;
  logic             is_arith;
  logic [DW-1:0]    ax;
  logic [DW-1:0]    ay;
  logic [DW:0]      shl;
  logic [DW:0]      diff;
  logic [DW:0]      sum;
  logic [DW:0]      dif;
  logic signed [2*DW-1:0] prod_sh;
  logic [2*DW-1:0]  q64;
  logic [DW-1:0]    op_res;
  pfe_pkg::status_t op_st;
  pfe_pkg::status_t st_nxt;
  logic [DW-1:0]    rep_top;

  // Decode the latched item
  assign has_two  = (sp_r >= SPW'(2));
  assign is_arith = (kind_r == pfe_pkg::KIND_APPLY) &&
                    ((op_r == pfe_pkg::OP_ADD) || (op_r == pfe_pkg::OP_SUB) ||
                     (op_r == pfe_pkg::OP_MUL) || (op_r == pfe_pkg::OP_DIV));

  always_comb begin
    stat           = '0;
    stat.need_read = has_two && (is_arith || (kind_r == pfe_pkg::KIND_FINISH));
    stat.is_mul    = (kind_r == pfe_pkg::KIND_APPLY) && (op_r == pfe_pkg::OP_MUL);
    stat.is_div    = (kind_r == pfe_pkg::KIND_APPLY) && (op_r == pfe_pkg::OP_DIV);
    stat.div_zero  = (top_r == '0);
    stat.div_last  = (cnt_r == CW'(1));
    stat.out_free  = !out_valid_r || !out_stall;
  end

  // Operand stack storage below the top entry
  pfe_ram #(
    .WIDTH (DW),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(sp_r - SPW'(1))),
    .wr_data (top_r),
    .rd_en   (cmd.rd_en),
    .rd_addr (AW'(sp_r - SPW'(2))),
    .rd_data (rd_data)
  );

  // Magnitudes of the operands for the divider
  assign ax = rd_data[DW-1] ? (~rd_data + DW'(1)) : rd_data;
  assign ay = top_r[DW-1] ? (~top_r + DW'(1)) : top_r;

  // One restoring division step
  assign shl  = {rem_r, dvd_r[QW-1]};
  assign diff = shl - {1'b0, ay_r};

  // Latch item, operands, product and divider
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      kind_r <= in_kind;
      num_r  <= in_number_value;
      op_r   <= in_operator_code;
    end
    if (cmd.capture) begin
      x_r   <= rd_data;
      dvd_r <= QW'({{DW{1'b0}}, ax} << FRACTION_BITS);
      rem_r <= '0;
      ay_r  <= ay;
      neg_r <= rd_data[DW-1] ^ top_r[DW-1];
      cnt_r <= CW'(QW);
    end
    if (cmd.mul_en) begin
      prod_r <= $signed(x_r) * $signed(top_r);
    end
    if (cmd.div_step) begin
      rem_r <= diff[DW] ? shl[DW-1:0] : diff[DW-1:0];
      dvd_r <= {dvd_r[QW-2:0], !diff[DW]};
      cnt_r <= cnt_r - CW'(1);
    end
  end

  // Arithmetic result with saturation
  assign sum     = {x_r[DW-1], x_r} + {top_r[DW-1], top_r};
  assign dif     = {x_r[DW-1], x_r} - {top_r[DW-1], top_r};
  assign prod_sh = prod_r >>> FRACTION_BITS;
  assign q64     = (2*DW)'(dvd_r);

  always_comb begin
    op_res = '0;
    op_st  = pfe_pkg::ST_OK;
    case (op_r)
      pfe_pkg::OP_ADD: begin
        op_res = sum[DW-1:0];
        if (sum[DW] != sum[DW-1]) begin
          op_res = sum[DW] ? pfe_pkg::Q_MIN : pfe_pkg::Q_MAX;
          op_st  = pfe_pkg::ST_SAT;
        end
      end
      pfe_pkg::OP_SUB: begin
        op_res = dif[DW-1:0];
        if (dif[DW] != dif[DW-1]) begin
          op_res = dif[DW] ? pfe_pkg::Q_MIN : pfe_pkg::Q_MAX;
          op_st  = pfe_pkg::ST_SAT;
        end
      end
      pfe_pkg::OP_MUL: begin
        op_res = prod_sh[DW-1:0];
        if (prod_sh > $signed({{DW{1'b0}}, pfe_pkg::Q_MAX})) begin
          op_res = pfe_pkg::Q_MAX;
          op_st  = pfe_pkg::ST_SAT;
        end else if (prod_sh < $signed({{DW{1'b1}}, pfe_pkg::Q_MIN})) begin
          op_res = pfe_pkg::Q_MIN;
          op_st  = pfe_pkg::ST_SAT;
        end
      end
      default: begin
        // Divide: zero divisor gives a signed limit, or zero for a zero dividend, else fix sign and clamp
        if (top_r == '0) begin
          op_st = pfe_pkg::ST_DIV0;
          if (x_r == '0) begin
            op_res = '0;
          end else begin
            op_res = x_r[DW-1] ? pfe_pkg::Q_MIN : pfe_pkg::Q_MAX;
          end
        end else if (!neg_r) begin
          op_res = q64[DW-1:0];
          if (q64[2*DW-1:DW-1] != '0) begin
            op_res = pfe_pkg::Q_MAX;
            op_st  = pfe_pkg::ST_SAT;
          end
        end else begin
          op_res = ~q64[DW-1:0] + DW'(1);
          if ((q64[2*DW-1:DW] != '0) || (q64[DW-1] && (q64[DW-2:0] != '0))) begin
            op_res = pfe_pkg::Q_MIN;
            op_st  = pfe_pkg::ST_SAT;
          end
        end
      end
    endcase
  end

  // Next stack state and reported values
  always_comb begin
    sp_nxt  = sp_r;
    top_nxt = top_r;
    st_nxt  = pfe_pkg::ST_OK;
    wr_en   = 1'b0;
    case (kind_r)
      pfe_pkg::KIND_PUSH: begin
        if (sp_r == SPW'(STACK_DEPTH)) begin
          st_nxt = pfe_pkg::ST_OVER;
        end else begin
          wr_en   = cmd.commit && (sp_r != '0);
          top_nxt = num_r;
          sp_nxt  = sp_r + SPW'(1);
        end
      end
      pfe_pkg::KIND_APPLY: begin
        if (is_arith) begin
          if (!has_two) begin
            st_nxt = pfe_pkg::ST_UNDER;
          end else begin
            top_nxt = op_res;
            st_nxt  = op_st;
            sp_nxt  = sp_r - SPW'(1);
          end
        end
      end
      pfe_pkg::KIND_FINISH: begin
        if (sp_r == '0) begin
          st_nxt = pfe_pkg::ST_UNDER;
        end else begin
          top_nxt = x_r;
          sp_nxt  = sp_r - SPW'(1);
        end
      end
      default: begin
        // Undefined kind: report the current top
      end
    endcase
    if ((kind_r == pfe_pkg::KIND_FINISH) && (sp_r != '0)) begin
      rep_top = top_r;
    end else begin
      rep_top = (sp_nxt != '0) ? top_nxt : '0;
    end
  end

  // Stack pointer and top register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r <= '0;
    end else if (cmd.commit) begin
      sp_r <= sp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      top_r <= top_nxt;
    end
  end

  // Result register: load on commit, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_top_r    <= rep_top;
      out_depth_r  <= pfe_pkg::DEPTH_W'(sp_nxt);
      out_status_r <= st_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_top_value   = out_top_r;
  assign out_stack_depth = out_depth_r;
  assign out_status      = out_status_r;

endmodule

@@ src/postfix_expression_evaluator_core.sv @@
`timescale 1ns / 1ps
// Channel   Handshake          Payload
// in_       in_valid/in_stall  in_kind, in_number_value, in_operator_code
// out_      out_valid/out_stall out_top_value, out_stack_depth, out_status
//
// One item at a time: latch, decode, then commit. Add, subtract, multiply,
// divide and finish with a stack read first read the entry below the top;
// multiply registers the product, and divide by a nonzero divisor runs the
// restoring divider, one quotient bit per cycle. Reset clears the controller
// state, the stack pointer and the result valid flag only. The next item is
// taken while a result waits; a stalled result holds the item after it.

module postfix_expression_evaluator_core #(
  parameter int STACK_DEPTH   = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [pfe_pkg::KIND_W-1:0]         in_kind,
  input  logic signed [pfe_pkg::DATA_W-1:0]  in_number_value,
  input  logic [pfe_pkg::OP_W-1:0]           in_operator_code,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [pfe_pkg::DATA_W-1:0]  out_top_value,
  output logic [pfe_pkg::DEPTH_W-1:0]        out_stack_depth,
  output logic [pfe_pkg::STATUS_W-1:0]       out_status
);

  pfe_pkg::pfe_cmd_t  cmd;
  pfe_pkg::pfe_stat_t stat;

  // Sequence each transaction
  pfe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Stack, arithmetic and result register
  pfe_datapath #(
    .STACK_DEPTH   (STACK_DEPTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_kind          (in_kind),
    .in_number_value  (in_number_value),
    .in_operator_code (in_operator_code),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_top_value    (out_top_value),
    .out_stack_depth  (out_stack_depth),
    .out_status       (out_status)
  );

endmodule

@@ test/postfix_expression_evaluator_core_tb.sv @@
`timescale 1ns / 1ps

module postfix_expression_evaluator_core_tb;
  import pfe_pkg::*;

  localparam int MAX_STACK    = 32;
  localparam int FRAC         = 16;
  localparam int HOLD_LEN     = 300;
  localparam int TAIL_CYCLES  = 120;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int PRINT_LIMIT  = 40;

  // Codes the package leaves unnamed
  localparam kind_t KIND_UNDEF     = 2'd3;
  localparam op_t   OP_NOP         = 3'd4;
  localparam op_t   OP_IGNORED_TOP = 3'd7;

  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;

  typedef struct packed {
    logic [DATA_W-1:0]  top;
    logic [DEPTH_W-1:0] depth;
    status_t            status;
  } rpn_result_t;

  typedef struct packed {
    kind_t             kind;
    logic [DATA_W-1:0] value;
    op_t               op;
    logic              typed;
    rpn_result_t       want;
  } token_row_t;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic [KIND_W-1:0]          in_kind;
  logic signed [DATA_W-1:0]   in_number_value;
  logic [OP_W-1:0]            in_operator_code;
  logic                       out_valid;
  logic                       out_stall;
  logic signed [DATA_W-1:0]   out_top_value;
  logic [DEPTH_W-1:0]         out_stack_depth;
  logic [STATUS_W-1:0]        out_status;

  // Typed expectation travelling alongside the token on the wire
  logic        drv_typed;
  rpn_result_t drv_want;

  // Shadow of the operand stack
  logic signed [DATA_W-1:0] shadow_stack [MAX_STACK];
  int                       shadow_depth = 0;

  rpn_result_t pending_results [$];
  int          mismatch_count = 0;
  int          tokens_offered = 0;
  int          tokens_accepted = 0;
  int          results_checked = 0;
  int          status_seen [8] = '{default: 0};
  int          cycle_count = 0;
  int          send_pct;
  int          recv_pct;
  int          hold_token;

  // Opening sequence, hand-checked where typed: empty-stack errors, saturation at both
  // ends, division by zero for each sign of the dividend, ignored codes
  token_row_t directed_rows [27] = '{
    '{KIND_FINISH, 32'h0,         OP_ADD,         1'b1, '{32'h0, 6'd0, ST_UNDER}},
    '{KIND_APPLY,  32'h0,         OP_ADD,         1'b1, '{32'h0, 6'd0, ST_UNDER}},
    '{KIND_PUSH,   Q_MAX,         OP_ADD,         1'b1, '{Q_MAX, 6'd1, ST_OK}},
    '{KIND_APPLY,  32'h0,         OP_MUL,         1'b1, '{Q_MAX, 6'd1, ST_UNDER}},
    '{KIND_PUSH,   32'h1,         OP_ADD,         1'b1, '{32'h1, 6'd2, ST_OK}},
    '{KIND_APPLY,  32'h0,         OP_ADD,         1'b1, '{Q_MAX, 6'd1, ST_SAT}},
    '{KIND_PUSH,   Q_MIN,         OP_ADD,         1'b1, '{Q_MIN, 6'd2, ST_OK}},
    '{KIND_APPLY,  32'h0,         OP_SUB,         1'b1, '{Q_MAX, 6'd1, ST_SAT}},
    '{KIND_PUSH,   32'h0,         OP_ADD,         1'b1, '{32'h0, 6'd2, ST_OK}},
    '{KIND_APPLY,  32'h0,         OP_DIV,         1'b1, '{Q_MAX, 6'd1, ST_DIV0}},
    '{KIND_PUSH,   Q_MIN,         OP_ADD,         1'b1, '{Q_MIN, 6'd2, ST_OK}},
    '{KIND_PUSH,   32'h0,         OP_ADD,         1'b1, '{32'h0, 6'd3, ST_OK}},
    '{KIND_APPLY,  32'h0,         OP_DIV,         1'b1, '{Q_MIN, 6'd2, ST_DIV0}},
    '{KIND_APPLY,  32'h0,         OP_MUL,         1'b1, '{Q_MIN, 6'd1, ST_SAT}},
    '{KIND_PUSH,   32'h0,         OP_ADD,         1'b1, '{32'h0, 6'd2, ST_OK}},
    '{KIND_PUSH,   32'h0,         OP_ADD,         1'b1, '{32'h0, 6'd3, ST_OK}},
    '{KIND_APPLY,  32'h0,         OP_DIV,         1'b1, '{32'h0, 6'd2, ST_DIV0}},
    '{KIND_APPLY,  32'h0,         OP_NOP,         1'b1, '{32'h0, 6'd2, ST_OK}},
    '{KIND_APPLY,  32'hffff_ffff, OP_IGNORED_TOP, 1'b1, '{32'h0, 6'd2, ST_OK}},
    '{KIND_UNDEF,  32'hffff_ffff, OP_IGNORED_TOP, 1'b1, '{32'h0, 6'd2, ST_OK}},
    '{KIND_PUSH,   32'h0002_0000, OP_ADD,         1'b0, '0},
    '{KIND_PUSH,   32'hfffe_8000, OP_ADD,         1'b0, '0},
    '{KIND_APPLY,  32'h0,         OP_MUL,         1'b0, '0},
    '{KIND_PUSH,   32'h0000_c000, OP_ADD,         1'b0, '0},
    '{KIND_APPLY,  32'h0,         OP_DIV,         1'b0, '0},
    '{KIND_APPLY,  32'h0,         OP_SUB,         1'b0, '0},
    '{KIND_FINISH, 32'h0,         OP_ADD,         1'b0, '0}
  };

  postfix_expression_evaluator_core #(
    .STACK_DEPTH   (MAX_STACK),
    .FRACTION_BITS (FRAC)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_number_value  (in_number_value),
    .in_operator_code (in_operator_code),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_top_value    (out_top_value),
    .out_stack_depth  (out_stack_depth),
    .out_status       (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Combine two Q16.16 operands, saturating to 32 bits
  function automatic logic [DATA_W-1:0] combine_operands(op_t op, longint lhs, longint rhs,
                                                         inout status_t st);
    longint          r;
    longint unsigned num;
    longint unsigned den;
    longint unsigned quo;
    if (op == OP_ADD) begin
      r = lhs + rhs;
    end else if (op == OP_SUB) begin
      r = lhs - rhs;
    end else if (op == OP_MUL) begin
      // arithmetic shift of a signed product rounds toward minus infinity
      r = (lhs * rhs) >>> FRAC;
    end else begin
      if (rhs == 0) begin
        st = ST_DIV0;
        if (lhs > 0) return Q_MAX;
        if (lhs < 0) return Q_MIN;
        return '0;
      end
      num = (lhs < 0 ? -lhs : lhs) << FRAC;
      den = rhs < 0 ? -rhs : rhs;
      quo = num / den;
      if (quo > (64'd1 << 40)) quo = 64'd1 << 40;
      r = ((lhs < 0) != (rhs < 0)) ? -longint'(quo) : longint'(quo);
    end
    if (r > SAT_HI) begin
      st = ST_SAT;
      r  = SAT_HI;
    end
    if (r < SAT_LO) begin
      st = ST_SAT;
      r  = SAT_LO;
    end
    return r[DATA_W-1:0];
  endfunction

  // Advance the shadow stack by one token and form its result
  function automatic rpn_result_t evaluate_token(kind_t kind, logic [DATA_W-1:0] value, op_t op);
    rpn_result_t res;
    status_t     st;
    longint      lhs;
    longint      rhs;
    bit          popped;
    st      = ST_OK;
    popped  = 1'b0;
    res.top = '0;
    if (kind == KIND_PUSH) begin
      if (shadow_depth >= MAX_STACK) begin
        st = ST_OVER;
      end else begin
        shadow_stack[shadow_depth] = value;
        shadow_depth++;
      end
    end else if (kind == KIND_APPLY && op <= OP_DIV) begin
      if (shadow_depth < 2) begin
        st = ST_UNDER;
      end else begin
        rhs = shadow_stack[shadow_depth-1];
        lhs = shadow_stack[shadow_depth-2];
        shadow_depth--;
        shadow_stack[shadow_depth-1] = combine_operands(op, lhs, rhs, st);
      end
    end else if (kind == KIND_FINISH) begin
      popped = 1'b1;
      if (shadow_depth == 0) begin
        st = ST_UNDER;
      end else begin
        shadow_depth--;
        res.top = shadow_stack[shadow_depth];
      end
    end
    if (!popped && shadow_depth > 0) res.top = shadow_stack[shadow_depth-1];
    res.depth  = DEPTH_W'(shadow_depth);
    res.status = st;
    return res;
  endfunction

  // Small operands so that divide and multiply stay in range, mixed with limits, zero and random words
  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom_range(0, 32'h000f_ffff) - 32'h0008_0000;
      4:          return Q_MAX;
      5:          return Q_MIN;
      6:          return '0;
      default:    return $urandom();
    endcase
  endfunction

  task automatic report_mismatch(string field, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT)
      $display("mismatch on %s at result %0d: got %h, want %h",
               field, results_checked, got, want);
  endtask

  // Offer one token and hold it until the block takes it
  task automatic offer_token(kind_t kind, logic [DATA_W-1:0] value, op_t op,
                             logic typed, rpn_result_t want);
    while ($urandom_range(0, 99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_kind          <= kind;
    in_number_value  <= value;
    in_operator_code <= op;
    drv_typed        <= typed;
    drv_want         <= want;
    tokens_offered++;
    do @(posedge clk); while (in_stall);
  endtask

  // Well-formed expression with random operands and operators, then finish
  task automatic offer_expression();
    int operands;
    int pushed;
    int live;
    int ops_left;
    operands = $urandom_range(1, 5);
    pushed   = 0;
    live     = 0;
    ops_left = operands - 1;
    while (pushed < operands || ops_left > 0) begin
      if (live >= 2 && ops_left > 0 && (pushed == operands || $urandom_range(0, 1))) begin
        offer_token(KIND_APPLY, $urandom(), op_t'($urandom_range(0, 3)), 1'b0, '0);
        live--;
        ops_left--;
      end else begin
        offer_token(KIND_PUSH, pick_value(), op_t'($urandom_range(0, 7)), 1'b0, '0);
        live++;
        pushed++;
      end
    end
    offer_token(KIND_FINISH, $urandom(), op_t'($urandom_range(0, 7)), 1'b0, '0);
  endtask

  task automatic run_random(int target);
    while (tokens_offered < target) begin
      if ($urandom_range(0, 99) < 80)
        offer_expression();
      else
        offer_token(kind_t'($urandom_range(0, 3)), pick_value(),
                    op_t'($urandom_range(0, 7)), 1'b0, '0);
    end
  endtask

  // Wait until every offered token has been taken and its result checked
  task automatic wait_for_results();
    while (tokens_accepted != tokens_offered || pending_results.size() != 0)
      @(posedge clk);
  endtask

  // Predict each token as the block accepts it
  always @(posedge clk) begin : token_capture
    rpn_result_t res;
    if (rst_n && in_valid && !in_stall) begin
      res = evaluate_token(in_kind, in_number_value, in_operator_code);
      if (drv_typed) res = drv_want;
      pending_results.push_back(res);
      tokens_accepted++;
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin : result_check
    rpn_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", out_top_value, '0);
      end else begin
        want = pending_results.pop_front();
        if (out_top_value !== want.top)
          report_mismatch("top_value", out_top_value, want.top);
        if (out_stack_depth !== want.depth)
          report_mismatch("stack_depth", DATA_W'(out_stack_depth), DATA_W'(want.depth));
        if (out_status !== want.status)
          report_mismatch("status", DATA_W'(out_status), DATA_W'(want.status));
      end
      status_seen[out_status]++;
      results_checked++;
    end
  end

  // Result side: random stalls, or a long hold-off when asked for
  initial begin : result_sink
    int hold_seen;
    hold_seen = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        out_stall <= 1'b1;
        repeat (HOLD_LEN - 1) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_pct);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin : stimulus
    int fill;
    int drain;
    hold_token       <= 0;
    send_pct         <= 14;
    recv_pct         <= 65;
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_kind          <= KIND_PUSH;
    in_number_value  <= '0;
    in_operator_code <= OP_ADD;
    drv_typed        <= 1'b0;
    drv_want         <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Phase one: sender idles lightly, receiver stalls heavily
    foreach (directed_rows[i])
      offer_token(directed_rows[i].kind, directed_rows[i].value, directed_rows[i].op,
                  directed_rows[i].typed, directed_rows[i].want);
    in_valid <= 1'b0;
    wait_for_results();

    // Hold the result side off while pushing past a full stack
    fill = MAX_STACK - shadow_depth + 2;
    hold_token <= hold_token + 1;
    repeat (fill)
      offer_token(KIND_PUSH, pick_value(), op_t'($urandom_range(0, 7)), 1'b0, '0);
    in_valid <= 1'b0;
    wait_for_results();

    // Pop everything, and once more on the empty stack
    drain = shadow_depth + 1;
    repeat (drain)
      offer_token(KIND_FINISH, $urandom(), op_t'($urandom_range(0, 7)), 1'b0, '0);
    run_random(tokens_offered + 150);

    // Phase two: roles swapped
    send_pct <= 65;
    recv_pct <= 14;
    run_random(tokens_offered + 150);

    // Phase three: full rate on both sides
    send_pct <= 0;
    recv_pct <= 0;
    run_random(tokens_offered + 150);
    in_valid <= 1'b0;

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("run covered %0d tokens and checked %0d results, incl. a %0d-cycle output hold",
             tokens_accepted, results_checked, HOLD_LEN);
    $display("results by status ok/under/over/div0/sat: %0d/%0d/%0d/%0d/%0d, mismatches %0d",
             status_seen[ST_OK], status_seen[ST_UNDER], status_seen[ST_OVER],
             status_seen[ST_DIV0], status_seen[ST_SAT], mismatch_count);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
